FILE: rtl/sgsg_pkg.sv
`timescale 1ns / 1ps

package sgsg_pkg;

  localparam int unsigned SegCount = 30;
  localparam int unsigned SegIdxW  = $clog2(SegCount);

  typedef logic [SegCount-1:0] seg_mask_t;

  // Glyph: line segments and dot-rectangle segments
  typedef struct packed {
    seg_mask_t lines;
    seg_mask_t rects;
  } glyph_t;

  // Segment endpoints on the cell grid (x 0..4, y 0..10)
  typedef struct packed {
    logic [2:0] x0;
    logic [3:0] y0;
    logic [2:0] x1;
    logic [3:0] y1;
  } seg_cells_t;

  // Configuration register indexes
  localparam logic [2:0] RegScale = 3'd0;
  localparam logic [2:0] RegBold  = 3'd1;
  localparam logic [2:0] RegRed   = 3'd2;
  localparam logic [2:0] RegGreen = 3'd3;
  localparam logic [2:0] RegBlue  = 3'd4;

  localparam logic [7:0] ScaleReset = 8'd16;

  // Shape kinds
  localparam logic KindLine = 1'b0;
  localparam logic KindRect = 1'b1;

  // Arrow codes
  localparam logic [7:0] CodeArrowLeft  = 8'd11;
  localparam logic [7:0] CodeArrowRight = 8'd12;
  localparam logic [7:0] CodeArrowUp    = 8'd13;
  localparam logic [7:0] CodeArrowDown  = 8'd14;
  localparam logic [7:0] CodeLastDigit  = 8'd9;

  // Microprogram steps
  localparam logic [1:0] StepIdle = 2'd0;
  localparam logic [1:0] StepDraw = 2'd1;
  localparam logic [1:0] StepBold = 2'd2;

  typedef struct packed {
    logic       take_in;   // step waits for and accepts an input transaction
    logic       emit;      // step issues a draw command (waits for output slot)
    logic       add_one;   // offset all endpoints by +1 pixel
    logic       br_bold;   // branch to tgt_bold for a line while bold is on
    logic       retire;    // clear the current segment from the work mask
    logic [1:0] tgt_bold;
    logic [1:0] tgt_done;  // taken when no segment remains
    logic [1:0] tgt_more;  // taken when segments remain
  } uword_t;

  function automatic uword_t ucode(input logic [1:0] pc);
    uword_t w;
    w = '0;
    unique case (pc)
      StepIdle: begin
        w.take_in  = 1'b1;
        w.tgt_done = StepIdle;
        w.tgt_more = StepDraw;
      end
      StepDraw: begin
        w.emit     = 1'b1;
        w.br_bold  = 1'b1;
        w.retire   = 1'b1;
        w.tgt_bold = StepBold;
        w.tgt_done = StepIdle;
        w.tgt_more = StepDraw;
      end
      StepBold: begin
        w.emit     = 1'b1;
        w.add_one  = 1'b1;
        w.retire   = 1'b1;
        w.tgt_done = StepIdle;
        w.tgt_more = StepDraw;
      end
      default: begin
        w.take_in  = 1'b0;
        w.tgt_done = StepIdle;
        w.tgt_more = StepIdle;
      end
    endcase
    return w;
  endfunction

  function automatic seg_mask_t sb(input int unsigned n);
    return seg_mask_t'(1) << n;
  endfunction

  function automatic glyph_t glyph_lookup(input logic [7:0] code);
    logic [7:0] c;
    glyph_t     g;
    c = code;
    g = '0;
    if (c <= CodeLastDigit) c = c + 8'd48;
    if (c >= "a" && c <= "z" && c != "v") c = c - 8'd32;
    case (c) inside
      "0": g.lines = seg_mask_t'(30'hFF) | sb(10) | sb(14);
      "1": g.lines = sb(2) | sb(3);
      "2": g.lines = sb(0) | sb(1) | sb(2) | sb(4) | sb(5) | sb(11) | sb(14);
      "3": g.lines = sb(0) | sb(1) | sb(2) | sb(3) | sb(4) | sb(5) | sb(11);
      "4": g.lines = sb(2) | sb(3) | sb(7) | sb(11) | sb(15);
      "5": g.lines = sb(0) | sb(1) | sb(4) | sb(5) | sb(7) | sb(12) | sb(15);
      "6": g.lines = sb(0) | sb(3) | sb(4) | sb(5) | sb(6) | sb(7) | sb(11) | sb(15);
      "7": g.lines = sb(0) | sb(1) | sb(10) | sb(14);
      "8": g.lines = seg_mask_t'(30'hFF) | sb(11) | sb(15);
      "9": g.lines = sb(0) | sb(1) | sb(2) | sb(3) | sb(4) | sb(7) | sb(11) | sb(15);
      ".": g.rects = sb(16);
      ":": g.rects = sb(16) | sb(17);
      ",": begin
        g.rects = sb(16);
        g.lines = sb(19);
      end
      ";": begin
        g.rects = sb(16) | sb(17);
        g.lines = sb(19);
      end
      "-": g.lines = sb(11) | sb(15);
      "+": g.lines = sb(9) | sb(11) | sb(13) | sb(15);
      "*": g.lines = sb(8) | sb(10) | sb(11) | sb(12) | sb(14) | sb(15);
      "/": g.lines = sb(10) | sb(14);
      "\\": g.lines = sb(8) | sb(12);
      "_": g.lines = sb(4) | sb(5);
      " ": g = '0;
      "A": g.lines = sb(0) | sb(1) | sb(2) | sb(3) | sb(6) | sb(7) | sb(11) | sb(15);
      "B": g.lines = seg_mask_t'(30'h3F) | sb(11) | sb(28);
      "C": g.lines = sb(0) | sb(1) | sb(4) | sb(5) | sb(6) | sb(7);
      "D": g.lines = seg_mask_t'(30'h3F) | sb(28);
      "E": g.lines = sb(0) | sb(1) | sb(4) | sb(5) | sb(6) | sb(7) | sb(15);
      "F": g.lines = sb(0) | sb(1) | sb(6) | sb(7) | sb(15);
      "G": g.lines = sb(0) | sb(1) | sb(3) | sb(4) | sb(5) | sb(6) | sb(7) | sb(11);
      "H": g.lines = sb(2) | sb(3) | sb(6) | sb(7) | sb(11) | sb(15);
      "I": g.lines = sb(0) | sb(1) | sb(4) | sb(5) | sb(9) | sb(13);
      "J": g.lines = sb(2) | sb(3) | sb(4) | sb(5) | sb(6);
      "K": g.lines = sb(6) | sb(7) | sb(10) | sb(12) | sb(15);
      "L": g.lines = sb(4) | sb(5) | sb(6) | sb(7);
      "M": g.lines = sb(2) | sb(3) | sb(6) | sb(7) | sb(8) | sb(10);
      "N": g.lines = sb(2) | sb(3) | sb(6) | sb(7) | sb(8) | sb(12);
      "O": g.lines = seg_mask_t'(30'hFF);
      "P": g.lines = sb(0) | sb(1) | sb(2) | sb(6) | sb(7) | sb(11) | sb(15);
      "Q": g.lines = seg_mask_t'(30'hFF) | sb(12);
      "R": g.lines = sb(0) | sb(1) | sb(2) | sb(6) | sb(7) | sb(11) | sb(12) | sb(15);
      "S": g.lines = sb(0) | sb(1) | sb(3) | sb(4) | sb(5) | sb(7) | sb(11) | sb(15);
      "T": g.lines = sb(0) | sb(1) | sb(9) | sb(13);
      "U": g.lines = sb(2) | sb(3) | sb(4) | sb(5) | sb(6) | sb(7);
      "V": g.lines = sb(6) | sb(7) | sb(10) | sb(14);
      "W": g.lines = sb(2) | sb(3) | sb(6) | sb(7) | sb(12) | sb(14);
      "X": g.lines = sb(8) | sb(10) | sb(12) | sb(14);
      "Y": g.lines = sb(8) | sb(10) | sb(13);
      "Z": g.lines = sb(0) | sb(1) | sb(4) | sb(5) | sb(10) | sb(14);
      "~": g.lines = sb(0) | sb(1);
      "@": g.lines = sb(1) | sb(2) | sb(3) | sb(4) | sb(11) | sb(13);
      "&": g.lines = sb(0) | sb(5) | sb(6) | sb(7) | sb(9) | sb(12) | sb(13) | sb(15);
      "%": begin
        g.lines = sb(10) | sb(14);
        g.rects = sb(16) | sb(18);
      end
      "$": g.lines = sb(0) | sb(1) | sb(3) | sb(4) | sb(5) | sb(7) | sb(9) | sb(11)
                   | sb(13) | sb(15);
      "[", "(", "{": g.lines = sb(0) | sb(5) | sb(6) | sb(7);
      "]", ")", "}": g.lines = sb(1) | sb(2) | sb(3) | sb(4);
      "!": begin
        g.lines = sb(9);
        g.rects = sb(16);
      end
      "?": begin
        g.lines = sb(0) | sb(1) | sb(2) | sb(11) | sb(13);
        g.rects = sb(16);
      end
      "|": g.lines = sb(9) | sb(13);
      "'", "\"": begin
        g.rects = sb(18);
        g.lines = sb(29);
      end
      ">": g.lines = sb(8) | sb(14);
      "<": g.lines = sb(10) | sb(12);
      "=": g.lines = sb(4) | sb(5) | sb(11) | sb(15);
      "^": g.lines = sb(12) | sb(14);
      "v": g.lines = sb(8) | sb(10);
      CodeArrowLeft:  g.lines = sb(11) | sb(15) | sb(24) | sb(25);
      CodeArrowRight: g.lines = sb(11) | sb(15) | sb(26) | sb(27);
      CodeArrowUp:    g.lines = sb(9) | sb(13) | sb(20) | sb(21);
      CodeArrowDown:  g.lines = sb(9) | sb(13) | sb(22) | sb(23);
      default: g.lines = sb(0) | sb(1) | sb(2) | sb(3) | sb(4) | sb(8) | sb(10)
                       | sb(12) | sb(14);
    endcase
    return g;
  endfunction

  function automatic seg_cells_t seg_cells(input logic [SegIdxW-1:0] idx);
    seg_cells_t s;
    case (idx)
      5'd0:  s = '{3'd0, 4'd0, 3'd2, 4'd0};
      5'd1:  s = '{3'd2, 4'd0, 3'd4, 4'd0};
      5'd2:  s = '{3'd4, 4'd0, 3'd4, 4'd4};
      5'd3:  s = '{3'd4, 4'd4, 3'd4, 4'd8};
      5'd4:  s = '{3'd4, 4'd8, 3'd2, 4'd8};
      5'd5:  s = '{3'd2, 4'd8, 3'd0, 4'd8};
      5'd6:  s = '{3'd0, 4'd8, 3'd0, 4'd4};
      5'd7:  s = '{3'd0, 4'd4, 3'd0, 4'd0};
      5'd8:  s = '{3'd2, 4'd4, 3'd0, 4'd0};
      5'd9:  s = '{3'd2, 4'd4, 3'd2, 4'd0};
      5'd10: s = '{3'd2, 4'd4, 3'd4, 4'd0};
      5'd11: s = '{3'd2, 4'd4, 3'd4, 4'd4};
      5'd12: s = '{3'd2, 4'd4, 3'd4, 4'd8};
      5'd13: s = '{3'd2, 4'd4, 3'd2, 4'd8};
      5'd14: s = '{3'd2, 4'd4, 3'd0, 4'd8};
      5'd15: s = '{3'd2, 4'd4, 3'd0, 4'd4};
      5'd16: s = '{3'd2, 4'd7, 3'd3, 4'd8};
      5'd17: s = '{3'd2, 4'd3, 3'd3, 4'd4};
      5'd18: s = '{3'd2, 4'd0, 3'd3, 4'd1};
      5'd19: s = '{3'd2, 4'd10, 3'd3, 4'd9};
      5'd20: s = '{3'd0, 4'd2, 3'd2, 4'd0};
      5'd21: s = '{3'd2, 4'd0, 3'd4, 4'd2};
      5'd22: s = '{3'd2, 4'd8, 3'd0, 4'd6};
      5'd23: s = '{3'd2, 4'd8, 3'd4, 4'd6};
      5'd24: s = '{3'd0, 4'd4, 3'd2, 4'd2};
      5'd25: s = '{3'd0, 4'd4, 3'd2, 4'd6};
      5'd26: s = '{3'd4, 4'd4, 3'd2, 4'd2};
      5'd27: s = '{3'd4, 4'd4, 3'd2, 4'd6};
      5'd28: s = '{3'd1, 4'd0, 3'd1, 4'd8};
      5'd29: s = '{3'd2, 4'd3, 3'd3, 4'd2};
      default: s = '0;
    endcase
    return s;
  endfunction

  // origin + floor(scale * grid_pos / 16), plus an optional one-pixel offset
  function automatic logic [12:0] place(input logic [11:0] origin,
                                        input logic [7:0]  scale,
                                        input logic [3:0]  grid_pos,
                                        input logic        add_one);
    logic [11:0] prod;
    prod = 12'(scale * grid_pos);
    return 13'(origin) + 13'(prod[11:4]) + 13'(add_one);
  endfunction

endpackage

FILE: rtl/segment_glyph_stroke_generator.sv
`timescale 1ns / 1ps

// Segment glyph stroke generator. Each input transaction carries a character
// code and the top-left pixel of its cell; the block looks the code up in a
// 30-segment glyph table and issues one draw command per active segment, in
// ascending segment order: a line, or a filled dot rectangle spanned by the
// two corners. Endpoints are origin + floor(scale * cell / 16), scale being
// unsigned with four fraction bits. With bold on, every line is followed by
// a copy shifted by one pixel in x and y. tlast marks the final command of a
// character; a space gives no command at all. Control is a three-step
// microprogram (accept, draw, bold copy) read from a constant table, with a
// step counter and branches on the remaining segment mask. The accept step
// takes the character, then each draw or bold step issues one command,
// stalling while the output slot is not free; the single shared endpoint
// unit issues one command per step. The input
// is only ready in the accept step. Colour, scale and bold are sampled when
// each command is built, so write them only while the block is idle.
module segment_glyph_stroke_generator
  import sgsg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [7:0]  cfg_data_i,

  // Character input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // char_code[7:0], origin_x[19:8], origin_y[31:20]

  // Draw command output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // start_x, start_y, end_x, end_y (13 b each),
                                      // red, green, blue (8 b each), zero pad
  output logic        m_axis_tuser,   // shape_kind
  output logic        m_axis_tlast
);

  // Configuration registers
  logic [7:0] scale_q, red_q, green_q, blue_q;
  logic       bold_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
      bold_q  <= 1'b0;
      red_q   <= '0;
      green_q <= '0;
      blue_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        RegScale: scale_q <= cfg_data_i;
        RegBold:  bold_q  <= cfg_data_i[0];
        RegRed:   red_q   <= cfg_data_i;
        RegGreen: green_q <= cfg_data_i;
        RegBlue:  blue_q  <= cfg_data_i;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // Sequencer state and working registers
  logic [1:0]  pc_q, pc_d;
  seg_mask_t   lines_q, lines_d, rects_q, rects_d;
  logic [11:0] ox_q, oy_q;

  uword_t uw;
  assign uw = ucode(pc_q);

  // Output register
  logic        out_valid_q;
  logic        out_kind_q, out_last_q;
  logic [12:0] out_x0_q, out_y0_q, out_x1_q, out_y1_q;
  logic [7:0]  out_red_q, out_green_q, out_blue_q;
  logic        slot_free;

  assign slot_free = !out_valid_q || m_axis_tready;

  // Lowest active segment
  seg_mask_t            active, cur_bit, rest;
  logic [SegIdxW-1:0]   cur_idx;
  logic                 cur_is_line;

  assign active  = lines_q | rects_q;
  assign cur_bit = active & (~active + seg_mask_t'(1));
  assign rest    = active & ~cur_bit;

  always_comb begin
    cur_idx = '0;
    for (int i = SegCount - 1; i >= 0; i--) begin
      if (active[i]) cur_idx = SegIdxW'(i);
    end
  end

  assign cur_is_line = |(lines_q & cur_bit);

  // Endpoint unit
  seg_cells_t cells;
  logic [12:0] x0, y0, x1, y1;

  assign cells = seg_cells(cur_idx);
  assign x0 = place(ox_q, scale_q, {1'b0, cells.x0}, uw.add_one);
  assign y0 = place(oy_q, scale_q, cells.y0, uw.add_one);
  assign x1 = place(ox_q, scale_q, {1'b0, cells.x1}, uw.add_one);
  assign y1 = place(oy_q, scale_q, cells.y1, uw.add_one);

  // Step control
  glyph_t new_glyph;
  logic   in_fire, step_fire, bold_taken, done;

  assign new_glyph     = glyph_lookup(s_axis_tdata[7:0]);
  assign s_axis_tready = uw.take_in;
  assign in_fire       = s_axis_tvalid && uw.take_in;
  assign step_fire     = uw.take_in ? s_axis_tvalid : (uw.emit && slot_free);
  assign bold_taken    = uw.br_bold && cur_is_line && bold_q;

  always_comb begin
    pc_d    = pc_q;
    lines_d = lines_q;
    rects_d = rects_q;
    done    = 1'b0;
    if (step_fire) begin
      if (uw.take_in) begin
        lines_d = new_glyph.lines;
        rects_d = new_glyph.rects;
        done    = ~|(new_glyph.lines | new_glyph.rects);
        pc_d    = done ? uw.tgt_done : uw.tgt_more;
      end else if (bold_taken) begin
        pc_d = uw.tgt_bold;
      end else begin
        if (uw.retire) begin
          lines_d = lines_q & ~cur_bit;
          rects_d = rects_q & ~cur_bit;
        end
        done = ~|rest;
        pc_d = done ? uw.tgt_done : uw.tgt_more;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= StepIdle;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (step_fire && uw.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lines_q <= lines_d;
    rects_q <= rects_d;
    if (in_fire) begin
      ox_q <= s_axis_tdata[19:8];
      oy_q <= s_axis_tdata[31:20];
    end
    if (step_fire && uw.emit) begin
      out_kind_q  <= cur_is_line ? KindLine : KindRect;
      out_last_q  <= !bold_taken && done;
      out_x0_q    <= x0;
      out_y0_q    <= y0;
      out_x1_q    <= x1;
      out_y1_q    <= y1;
      out_red_q   <= red_q;
      out_green_q <= green_q;
      out_blue_q  <= blue_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_blue_q, out_green_q, out_red_q,
                          out_y1_q, out_x1_q, out_y0_q, out_x0_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule
